[rtl/core/btmx_pkg.sv]
// Shared types, constants and codes of the binary trie maximum-XOR block.
package btmx_pkg;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 65536;
    localparam int COUNT_BITS = 16;

    localparam int LINK_BITS = $clog2(NODE_COUNT);
    localparam int PTR_BITS  = $clog2(NODE_COUNT + 1);
    localparam int CAP_BITS  = PTR_BITS + 8;
    localparam int IDX_BITS  = $clog2(KEY_BITS);

    typedef logic [1:0]            action_t;
    typedef logic [31:0]           word_t;
    typedef logic [1:0]            status_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [LINK_BITS-1:0]  link_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [CAP_BITS-1:0]   cap_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [1:0]            walk_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_REMOVE = 2'd1;
    localparam action_t ACT_QUERY  = 2'd2;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_FULL   = 2'd2;
    localparam status_t ST_ABSENT = 2'd3;

    localparam walk_t WALK_NONE   = 2'd0;
    localparam walk_t WALK_CHECK  = 2'd1;
    localparam walk_t WALK_UPDATE = 2'd2;
    localparam walk_t WALK_QUERY  = 2'd3;

    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        link_t  zero;
        link_t  one;
        count_t count;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    restart;
        logic    step_a;
        logic    step_b;
        logic    leaf;
        logic    emit;
        walk_t   walk;
        status_t status;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    last_bit;
        logic    child_missing;
        logic    child_empty;
        logic    set_empty;
        logic    total_full;
        logic    pool_room;
        logic    pool_fits;
        logic    out_free;
    } stat_t;

endpackage

[rtl/core/btmx_req_if.sv]
// Request channel: one action and key per beat.
interface btmx_req_if;
    logic               valid;
    logic               ready;
    btmx_pkg::action_t  action;
    btmx_pkg::word_t    key;

    modport source (output valid, output action, output key, input ready);
    modport sink (input valid, input action, input key, output ready);
endinterface

[rtl/core/btmx_rsp_if.sv]
// Response channel: one result and status per beat.
interface btmx_rsp_if;
    logic               valid;
    logic               ready;
    btmx_pkg::word_t    best_xor;
    btmx_pkg::status_t  status;

    modport source (output valid, output best_xor, output status, input ready);
    modport sink (input valid, input best_xor, input status, output ready);
endinterface

[rtl/core/btmx_ctrl.sv]
// Controller state machine that sequences the trie walks.
module btmx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output btmx_pkg::cmd_t    cmd,
    input  btmx_pkg::stat_t   stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_CHK_A = 4'd2;
    localparam logic [3:0] S_CHK_B = 4'd3;
    localparam logic [3:0] S_UPD_A = 4'd4;
    localparam logic [3:0] S_UPD_B = 4'd5;
    localparam logic [3:0] S_UPD_W = 4'd6;
    localparam logic [3:0] S_QRY_A = 4'd7;
    localparam logic [3:0] S_QRY_B = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    btmx_pkg::status_t  status_reg;
    btmx_pkg::status_t  status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        req_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = btmx_pkg::ST_OK;
                unique case (stat.action)
                    btmx_pkg::ACT_INSERT:
                    begin
                        priority if (stat.total_full)
                        begin
                            status_next = btmx_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (stat.pool_room)
                        begin
                            state_next = S_UPD_A;
                        end
                        else
                        begin
                            state_next = S_CHK_A;
                        end
                    end
                    btmx_pkg::ACT_REMOVE:
                    begin
                        state_next = S_CHK_A;
                    end
                    btmx_pkg::ACT_QUERY:
                    begin
                        if (stat.set_empty)
                        begin
                            status_next = btmx_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_QRY_A;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CHK_A:
            begin
                cmd.walk   = btmx_pkg::WALK_CHECK;
                cmd.step_a = 1'b1;
                if (stat.child_missing)
                begin
                    if (stat.action == btmx_pkg::ACT_INSERT)
                    begin
                        if (stat.pool_fits)
                        begin
                            cmd.restart = 1'b1;
                            state_next  = S_UPD_A;
                        end
                        else
                        begin
                            status_next = btmx_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        status_next = btmx_pkg::ST_ABSENT;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CHK_B;
                end
            end
            S_CHK_B:
            begin
                cmd.walk = btmx_pkg::WALK_CHECK;
                priority if (stat.action == btmx_pkg::ACT_REMOVE && stat.child_empty)
                begin
                    status_next = btmx_pkg::ST_ABSENT;
                    state_next  = S_DONE;
                end
                else if (stat.last_bit)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_UPD_A;
                end
                else
                begin
                    cmd.step_b = 1'b1;
                    state_next = S_CHK_A;
                end
            end
            S_UPD_A:
            begin
                cmd.walk   = btmx_pkg::WALK_UPDATE;
                cmd.step_a = 1'b1;
                state_next = S_UPD_B;
            end
            S_UPD_B:
            begin
                cmd.walk   = btmx_pkg::WALK_UPDATE;
                cmd.step_b = 1'b1;
                state_next = stat.last_bit ? S_UPD_W : S_UPD_A;
            end
            S_UPD_W:
            begin
                cmd.leaf    = 1'b1;
                status_next = btmx_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_QRY_A:
            begin
                cmd.walk   = btmx_pkg::WALK_QUERY;
                state_next = S_QRY_B;
            end
            S_QRY_B:
            begin
                cmd.walk   = btmx_pkg::WALK_QUERY;
                cmd.step_b = 1'b1;
                state_next = stat.last_bit ? S_DONE : S_QRY_A;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= btmx_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written while the output register is occupied");

    a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QRY_A |-> !stat.set_empty)
        else $error("query walk started on an empty set");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD_A && stat.action == btmx_pkg::ACT_INSERT) |-> !stat.total_full)
        else $error("insert update walk with the key count at its limit");
`endif

endmodule

[rtl/core/btmx_dp.sv]
// Datapath: node memory, walk registers, counters and the result register.
module btmx_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  btmx_pkg::action_t  req_action,
    input  btmx_pkg::word_t    req_key,
    input  btmx_pkg::cmd_t     cmd,
    output btmx_pkg::stat_t    stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output btmx_pkg::word_t    rsp_best_xor,
    output btmx_pkg::status_t  rsp_status
);

    btmx_pkg::entry_t   mem [btmx_pkg::NODE_COUNT];
    btmx_pkg::entry_t   rd0_reg;
    btmx_pkg::entry_t   rd1_reg;

    btmx_pkg::action_t  action_reg;
    btmx_pkg::key_t     key_reg;
    btmx_pkg::key_t     best_reg;
    btmx_pkg::idx_t     idx_reg;
    btmx_pkg::link_t    cur_node_reg;
    btmx_pkg::link_t    cur_zero_reg;
    btmx_pkg::link_t    cur_one_reg;
    btmx_pkg::count_t   cur_count_reg;
    logic               alloc_reg;
    btmx_pkg::link_t    child_reg;

    btmx_pkg::link_t    root_zero_reg;
    btmx_pkg::link_t    root_one_reg;
    btmx_pkg::ptr_t     next_free_reg;
    btmx_pkg::count_t   total_reg;

    logic               rsp_valid_reg;
    btmx_pkg::word_t    rsp_best_reg;
    btmx_pkg::status_t  rsp_status_reg;

    logic               bit_now;
    btmx_pkg::link_t    link_b;
    btmx_pkg::link_t    link_opp;
    btmx_pkg::entry_t   rd_b;
    btmx_pkg::entry_t   rd_opp;
    logic               take_opp;
    logic               alloc_now;
    logic               is_insert;
    btmx_pkg::link_t    new_node;
    btmx_pkg::entry_t   wb_entry;
    btmx_pkg::count_t   step_count;
    logic               mem_we;
    btmx_pkg::link_t    mem_waddr;
    btmx_pkg::entry_t   mem_wdata;

    always_comb
    begin
        bit_now    = key_reg[idx_reg];
        link_b     = bit_now ? cur_one_reg : cur_zero_reg;
        link_opp   = bit_now ? cur_zero_reg : cur_one_reg;
        rd_b       = bit_now ? rd1_reg : rd0_reg;
        rd_opp     = bit_now ? rd0_reg : rd1_reg;
        take_opp   = (link_opp != '0) && (rd_opp.count != '0);
        alloc_now  = (link_b == '0);
        is_insert  = (action_reg == btmx_pkg::ACT_INSERT);
        new_node   = next_free_reg[btmx_pkg::LINK_BITS-1:0];
        step_count = is_insert ? rd_b.count + btmx_pkg::count_t'(1)
                               : rd_b.count - btmx_pkg::count_t'(1);

        wb_entry.zero  = (alloc_now && !bit_now) ? new_node : cur_zero_reg;
        wb_entry.one   = (alloc_now && bit_now) ? new_node : cur_one_reg;
        wb_entry.count = cur_count_reg;

        mem_we    = 1'b0;
        mem_waddr = cur_node_reg;
        mem_wdata = wb_entry;
        if (cmd.step_a && cmd.walk == btmx_pkg::WALK_UPDATE && cur_node_reg != '0)
        begin
            mem_we = 1'b1;
        end
        if (cmd.leaf)
        begin
            mem_we    = 1'b1;
            mem_wdata = '{zero: cur_zero_reg, one: cur_one_reg, count: cur_count_reg};
        end

        stat.action        = action_reg;
        stat.last_bit      = (idx_reg == '0);
        stat.child_missing = alloc_now;
        stat.child_empty   = (rd_b.count == '0);
        stat.set_empty     = (total_reg == '0);
        stat.total_full    = (total_reg == btmx_pkg::COUNT_MAX);
        stat.pool_room     = (btmx_pkg::cap_t'(next_free_reg)
                              + btmx_pkg::cap_t'(btmx_pkg::KEY_BITS))
                             <= btmx_pkg::cap_t'(btmx_pkg::NODE_COUNT);
        stat.pool_fits     = (btmx_pkg::cap_t'(next_free_reg) + btmx_pkg::cap_t'(idx_reg)
                              + btmx_pkg::cap_t'(1))
                             <= btmx_pkg::cap_t'(btmx_pkg::NODE_COUNT);
        stat.out_free      = !rsp_valid_reg || rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= mem[cur_zero_reg];
        rd1_reg <= mem[cur_one_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_zero_reg <= '0;
            root_one_reg  <= '0;
            next_free_reg <= btmx_pkg::ptr_t'(1);
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step_a && cmd.walk == btmx_pkg::WALK_UPDATE && alloc_now)
            begin
                next_free_reg <= next_free_reg + btmx_pkg::ptr_t'(1);
                if (cur_node_reg == '0)
                begin
                    if (bit_now)
                    begin
                        root_one_reg <= new_node;
                    end
                    else
                    begin
                        root_zero_reg <= new_node;
                    end
                end
            end
            if (cmd.leaf)
            begin
                if (is_insert)
                begin
                    total_reg <= total_reg + btmx_pkg::count_t'(1);
                end
                else if (total_reg != '0)
                begin
                    total_reg <= total_reg - btmx_pkg::count_t'(1);
                end
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= req_action;
            key_reg    <= btmx_pkg::key_t'(req_key);
            best_reg   <= '0;
        end
        if (cmd.load || cmd.restart)
        begin
            idx_reg       <= btmx_pkg::idx_t'(btmx_pkg::KEY_BITS - 1);
            cur_node_reg  <= '0;
            cur_zero_reg  <= root_zero_reg;
            cur_one_reg   <= root_one_reg;
            cur_count_reg <= '0;
        end
        else if (cmd.step_b)
        begin
            if (idx_reg != '0)
            begin
                idx_reg <= idx_reg - btmx_pkg::idx_t'(1);
            end
            unique case (cmd.walk)
                btmx_pkg::WALK_CHECK:
                begin
                    cur_node_reg  <= link_b;
                    cur_zero_reg  <= rd_b.zero;
                    cur_one_reg   <= rd_b.one;
                    cur_count_reg <= rd_b.count;
                end
                btmx_pkg::WALK_UPDATE:
                begin
                    cur_node_reg <= child_reg;
                    if (alloc_reg)
                    begin
                        cur_zero_reg  <= '0;
                        cur_one_reg   <= '0;
                        cur_count_reg <= btmx_pkg::count_t'(1);
                    end
                    else
                    begin
                        cur_zero_reg  <= rd_b.zero;
                        cur_one_reg   <= rd_b.one;
                        cur_count_reg <= step_count;
                    end
                end
                btmx_pkg::WALK_QUERY:
                begin
                    if (take_opp)
                    begin
                        best_reg[idx_reg] <= 1'b1;
                        cur_node_reg      <= link_opp;
                        cur_zero_reg      <= rd_opp.zero;
                        cur_one_reg       <= rd_opp.one;
                        cur_count_reg     <= rd_opp.count;
                    end
                    else
                    begin
                        cur_node_reg  <= link_b;
                        cur_zero_reg  <= rd_b.zero;
                        cur_one_reg   <= rd_b.one;
                        cur_count_reg <= rd_b.count;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.step_a && cmd.walk == btmx_pkg::WALK_UPDATE)
        begin
            alloc_reg <= alloc_now;
            child_reg <= alloc_now ? new_node : link_b;
        end
        if (cmd.emit)
        begin
            rsp_best_reg   <= btmx_pkg::word_t'(best_reg);
            rsp_status_reg <= cmd.status;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_best_xor = rsp_best_reg;
    assign rsp_status   = rsp_status_reg;

`ifndef SYNTH
    a_alloc_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_a && cmd.walk == btmx_pkg::WALK_UPDATE && alloc_now)
        |-> next_free_reg < btmx_pkg::ptr_t'(btmx_pkg::NODE_COUNT))
        else $error("node allocated beyond the end of the pool");

    a_leaf_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.leaf |-> cur_node_reg != '0)
        else $error("leaf write-back addressed the root");

    a_best_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && best_reg != '0)
        |-> (action_reg == btmx_pkg::ACT_QUERY && cmd.status == btmx_pkg::ST_OK))
        else $error("nonzero XOR result for an item that is not a successful query");
`endif

endmodule

[rtl/core/binary_trie_max_xor.sv]
// A query walks the trie from the root once; an insert walks it once, then writes the leaf.
// Insert with fewer than KEY_BITS free nodes and every remove add a checking walk first.
// A new request is taken only in the idle state, after the last result is written out.
// Each trie level takes an A and a B step, as the node memory read port is registered.
// Reset empties the set, frees the node pool and clears the output valid flag; the
// node memory itself is not cleared, since every node is written when allocated.
module binary_trie_max_xor (
    input  logic     clk,
    input  logic     rst_n,
    btmx_req_if.sink req,
    btmx_rsp_if.source rsp
);

    btmx_pkg::cmd_t   cmd;
    btmx_pkg::stat_t  stat;

    btmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    btmx_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_action   (req.action),
        .req_key      (req.key),
        .cmd          (cmd),
        .stat         (stat),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_best_xor (rsp.best_xor),
        .rsp_status   (rsp.status)
    );

endmodule
